### rtl/nesa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nesa_pkg
// Shared types and constants of the neighbor exclusive seat arbiter.
// ----------------------------------------------------------------------------
package nesa_pkg;

   typedef enum logic [1:0] {
      CMD_ASK_EAT   = 2'd0,
      CMD_DONE_EAT  = 2'd1,
      CMD_ASK_SING  = 2'd2,
      CMD_DONE_SING = 2'd3
   } cmd_type;

   localparam logic KIND_EAT  = 1'b0;
   localparam logic KIND_SING = 1'b1;

   localparam int          SEAT_W          = 4;
   localparam int          NUM_SEATS_W     = 5;
   localparam logic [4:0]  NUM_SEATS_RESET = 5'd5;
   localparam int          MIN_SEATS       = 2;

   typedef struct packed {
      cmd_type           cmd;
      logic [SEAT_W-1:0] seat;
   } req_type;

   typedef struct packed {
      logic [SEAT_W-1:0] grant_seat;
      logic              grant_kind;
      logic              last;
   } rsp_type;

   // Handshake between the front stage and the queue.
   typedef struct packed {
      logic push;
      logic full;
   } q_ctrl_type;

endpackage

### rtl/nesa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nesa_front
// Input stage: takes request beats, drops seats outside the ring, and hands
// the rest to the command queue.
// ----------------------------------------------------------------------------
module nesa_front
   import nesa_pkg::*;
#(
   parameter int MAX_SEATS = 16,
   parameter int CW        = $clog2(MAX_SEATS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] ring_n,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   input  logic          q_full,
   output q_ctrl_type    q_ctrl,
   output req_type       q_wdata
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    push;
   logic    accept;
   logic    in_ring;

   assign push      = valid_ff && !q_full;
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign in_ring   = 32'(req_data.seat) < 32'(ring_n);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      // drop beats whose seat is outside the ring
      if (accept) begin
         valid_in = in_ring;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign q_ctrl.push = push;
   assign q_ctrl.full = q_full;
   assign q_wdata     = data_ff;

endmodule

### rtl/nesa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nesa_queue
// Two-entry command queue between the front stage and the seat sequencer.
// ----------------------------------------------------------------------------
module nesa_queue
   import nesa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_ctrl_type q_ctrl,
   input  req_type    q_wdata,
   output logic       q_full,
   input  logic       q_pop,
   output logic       q_valid,
   output req_type    q_rdata
);

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign q_full  = count_ff == 2'd2;
   assign q_valid = count_ff != 2'd0;
   assign q_rdata = slot_ff[rd_ptr_ff];
   assign do_push = q_ctrl.push && !q_ctrl.full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

### rtl/nesa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nesa_seq
// Seat sequencer: holds the state of every seat, carries out one command at
// a time and issues grant beats through an output register.
// ----------------------------------------------------------------------------
module nesa_seq
   import nesa_pkg::*;
#(
   parameter int MAX_SEATS = 16,
   parameter int SW        = $clog2(MAX_SEATS),
   parameter int CW        = $clog2(MAX_SEATS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] ring_n,
   input  logic          q_valid,
   input  req_type       q_rdata,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SECOND,
      S_WRAP,
      S_SCAN
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [SW-1:0]          seat_ff, seat_in;
   logic [SW-1:0]          second_ff, second_in;
   logic [SW-1:0]          scan_ff, scan_in;
   logic [SW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [MAX_SEATS-1:0]   hungry_ff, hungry_in;
   logic [MAX_SEATS-1:0]   eat_ff, eat_in;
   logic [MAX_SEATS-1:0]   wait_ff, wait_in;
   logic [MAX_SEATS-1:0]   sing_ff, sing_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [MAX_SEATS-1:0]   ring_mask;
   logic [MAX_SEATS-1:0]   seat_oh;
   logic [MAX_SEATS-1:0]   l_oh;
   logic [MAX_SEATS-1:0]   r_oh;
   logic [MAX_SEATS-1:0]   eat_rel;
   logic [MAX_SEATS-1:0]   eat_l;
   logic [MAX_SEATS-1:0]   hungry_l;
   logic [SW-1:0]          left_s;
   logic [SW-1:0]          right_s;
   logic                   thinking;
   logic                   sing_any;
   logic                   grant_ask;
   logic                   grant_l;
   logic                   grant_r;
   logic                   out_free;

   function automatic logic [SW-1:0] left_of(input logic [SW-1:0] i,
                                             input logic [CW-1:0] n);
      return (i == '0) ? SW'(n - CW'(1)) : SW'(i - SW'(1));
   endfunction

   function automatic logic [SW-1:0] right_of(input logic [SW-1:0] i,
                                              input logic [CW-1:0] n);
      return (CW'(i) + CW'(1) == n) ? '0 : SW'(i + SW'(1));
   endfunction

   function automatic rsp_type make_rsp(input logic [SW-1:0] s, input logic kind,
                                        input logic fin);
      rsp_type r;
      r.grant_seat = SEAT_W'(s);
      r.grant_kind = kind;
      r.last       = fin;
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < MAX_SEATS; i++) begin
         ring_mask[i] = 32'(i) < 32'(ring_n);
      end
   end

   assign left_s   = left_of(seat_ff, ring_n);
   assign right_s  = right_of(seat_ff, ring_n);
   assign seat_oh  = MAX_SEATS'(1) << seat_ff;
   assign l_oh     = MAX_SEATS'(1) << left_s;
   assign r_oh     = MAX_SEATS'(1) << right_s;
   assign thinking = !(hungry_ff[seat_ff] || eat_ff[seat_ff] ||
                       wait_ff[seat_ff] || sing_ff[seat_ff]);
   assign sing_any = |(sing_ff & ring_mask);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // eat request: both neighbors must be off the resource
   assign grant_ask = !eat_ff[left_s] && !eat_ff[right_s];

   // eat release: retest the left neighbor, then the right one on top of it
   assign eat_rel  = eat_ff & ~seat_oh;
   assign grant_l  = hungry_ff[left_s] && !eat_rel[left_of(left_s, ring_n)] &&
                     !eat_rel[right_of(left_s, ring_n)];
   assign eat_l    = grant_l ? (eat_rel | l_oh) : eat_rel;
   assign hungry_l = grant_l ? (hungry_ff & ~l_oh) : hungry_ff;
   assign grant_r  = hungry_l[right_s] && !eat_l[left_of(right_s, ring_n)] &&
                     !eat_l[right_of(right_s, ring_n)];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      seat_in      = seat_ff;
      second_in    = second_ff;
      scan_in      = scan_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      hungry_in    = hungry_ff;
      eat_in       = eat_ff;
      wait_in      = wait_ff;
      sing_in      = sing_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_rdata.cmd;
               seat_in  = SW'(q_rdata.seat);
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            case (cmd_ff)
               CMD_ASK_EAT: begin
                  if (!thinking) begin
                     state_in = S_IDLE;
                  end else if (!grant_ask) begin
                     hungry_in = hungry_ff | seat_oh;
                     state_in  = S_IDLE;
                  end else if (out_free) begin
                     eat_in       = eat_ff | seat_oh;
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(seat_ff, KIND_EAT, 1'b1);
                     state_in     = S_IDLE;
                  end
               end

               CMD_DONE_EAT: begin
                  if (!eat_ff[seat_ff]) begin
                     state_in = S_IDLE;
                  end else if (!grant_l && !grant_r) begin
                     eat_in   = eat_rel;
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     eat_in       = grant_r ? (eat_l | r_oh) : eat_l;
                     hungry_in    = grant_r ? (hungry_l & ~r_oh) : hungry_l;
                     rsp_valid_in = 1'b1;
                     if (grant_l) begin
                        rsp_in = make_rsp(left_s, KIND_EAT, !grant_r);
                     end else begin
                        rsp_in = make_rsp(right_s, KIND_EAT, 1'b1);
                     end
                     // hold the right grant for the next beat
                     second_in = right_s;
                     state_in  = (grant_l && grant_r) ? S_SECOND : S_IDLE;
                  end
               end

               CMD_ASK_SING: begin
                  if (!thinking) begin
                     state_in = S_IDLE;
                  end else if (sing_any) begin
                     wait_in  = wait_ff | seat_oh;
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     sing_in      = sing_ff | seat_oh;
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(seat_ff, KIND_SING, 1'b1);
                     state_in     = S_IDLE;
                  end
               end

               CMD_DONE_SING: begin
                  if (!sing_ff[seat_ff]) begin
                     state_in = S_IDLE;
                  end else begin
                     sing_in  = sing_ff & ~seat_oh;
                     state_in = S_WRAP;
                  end
               end

               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SECOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(second_ff, KIND_EAT, 1'b1);
               state_in     = S_IDLE;
            end
         end

         S_WRAP: begin
            // bring a stale start pointer back into the ring
            if (CW'(scan_ff) >= ring_n) begin
               scan_in = SW'(CW'(scan_ff) - ring_n);
            end else begin
               scan_in = right_of(scan_ff, ring_n);
               ptr_in  = scan_ff;
               cnt_in  = '0;
               state_in = sing_any ? S_IDLE : S_SCAN;
            end
         end

         S_SCAN: begin
            if (wait_ff[ptr_ff]) begin
               if (out_free) begin
                  wait_in      = wait_ff & ~(MAX_SEATS'(1) << ptr_ff);
                  sing_in      = sing_ff | (MAX_SEATS'(1) << ptr_ff);
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(ptr_ff, KIND_SING, 1'b1);
                  state_in     = S_IDLE;
               end
            end else if (cnt_ff + CW'(1) == ring_n) begin
               state_in = S_IDLE;
            end else begin
               ptr_in = right_of(ptr_ff, ring_n);
               cnt_in = cnt_ff + CW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         hungry_ff    <= '0;
         eat_ff       <= '0;
         wait_ff      <= '0;
         sing_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         hungry_ff    <= hungry_in;
         eat_ff       <= eat_in;
         wait_ff      <= wait_in;
         sing_ff      <= sing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      seat_ff   <= seat_in;
      second_ff <= second_in;
      ptr_ff    <= ptr_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/neighbor_exclusive_seat_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_exclusive_seat_arbiter
// Ring of seats sharing an eat resource (neighbor exclusive) and a sing
// resource (ring exclusive); issues one grant beat per granted seat.
//
//   channel   ports                          beat
//   request   req_valid  req_stall req_data  cmd, seat
//   response  rsp_valid  rsp_stall rsp_data  grant_seat, grant_kind, last
//   config    csr_wr_en  csr_wr_data         num_seats
//
// An accepted request is registered in the input stage, then passes a
// two-entry queue to the sequencer; an eat release that grants both
// neighbors adds an S_SECOND state, and a sing release runs pointer wrap
// steps and then up to one scan step per seat in the ring.
// Reset is synchronous: all seats thinking, scan pointer zero, num_seats 5.
// A stalled response holds the next grant; the queue fills up meanwhile.
// ----------------------------------------------------------------------------
module neighbor_exclusive_seat_arbiter
   import nesa_pkg::*;
#(
   parameter int MAX_SEATS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [NUM_SEATS_W-1:0] csr_wr_data
);

   localparam int SW = $clog2(MAX_SEATS);
   localparam int CW = $clog2(MAX_SEATS + 1);

   logic [NUM_SEATS_W-1:0] num_seats_ff, num_seats_in;
   logic [CW-1:0]          ring_n;
   q_ctrl_type             q_ctrl;
   req_type                q_wdata;
   req_type                q_rdata;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;

   assign num_seats_in = csr_wr_en ? csr_wr_data : num_seats_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_seats_ff <= NUM_SEATS_RESET;
      end else begin
         num_seats_ff <= num_seats_in;
      end
   end

   // clamp the seat count into the supported range
   always_comb begin
      if (32'(num_seats_ff) < MIN_SEATS) begin
         ring_n = CW'(MIN_SEATS);
      end else if (32'(num_seats_ff) > MAX_SEATS) begin
         ring_n = CW'(MAX_SEATS);
      end else begin
         ring_n = CW'(num_seats_ff);
      end
   end

   nesa_front #(
      .MAX_SEATS (MAX_SEATS),
      .CW        (CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .ring_n    (ring_n),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_ctrl    (q_ctrl),
      .q_wdata   (q_wdata)
   );

   nesa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_ctrl  (q_ctrl),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_rdata (q_rdata)
   );

   nesa_seq #(
      .MAX_SEATS (MAX_SEATS),
      .SW        (SW),
      .CW        (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .ring_n    (ring_n),
      .q_valid   (q_valid),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
